// ===== rtl/core/fec_pkg.sv =====
// Shared constants and types for the fill encoding chooser.
// No dependencies; every other file of the block imports this package.
package fec_pkg;

    localparam int unsigned MAX_PERIOD_DEF  = 256;
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // Width of the size and run count result fields.
    localparam int unsigned SIZE_W = 32;

    // Header bytes in front of a run-length or pattern payload, and the
    // bytes that one run costs in the run-length form.
    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned RUN_BYTES = 5;

    // Period flags are searched in groups of this many per pipeline stage.
    localparam int unsigned GROUP_SIZE = 16;

    localparam logic [1:0] ENC_RAW     = 2'd0;
    localparam logic [1:0] ENC_ZERO    = 2'd1;
    localparam logic [1:0] ENC_RLE     = 2'd2;
    localparam logic [1:0] ENC_PATTERN = 2'd3;

    // Control that the front end hands to every period cell.
    typedef struct packed {
        logic upd;   // item counted: update flag and phase
        logic clr;   // last item taken: return to the empty state
    } t_cell_ctl;

    // Summary flags of a finished payload.
    typedef struct packed {
        logic any_nz;  // some byte was nonzero
        logic sat;     // length counter saturated
    } t_flags;

endpackage

// ===== rtl/core/fec_cell.sv =====
// One candidate period: the "repeats so far" flag and the phase counter.
// Depends on fec_pkg; instantiated by fec_front once per period.
module fec_cell #(
    parameter int unsigned P           = 1,
    parameter int unsigned COUNT_WIDTH = fec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fec_pkg::t_cell_ctl     i_ctl,
    input  logic [7:0]             i_byte,
    input  logic [7:0]             i_tap,
    input  logic                   i_tap_vld,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic                   o_qual
);
    import fec_pkg::*;

    localparam int unsigned PW   = (P > 1) ? $clog2(P) : 1;
    localparam int unsigned CMPW = (COUNT_WIDTH > 12) ? COUNT_WIDTH : 12;
    localparam logic [CMPW-1:0] LEN_MIN = CMPW'(2 * P - 1);
    localparam logic [PW-1:0]   PH_LAST = PW'(P - 1);

    logic          r_periodic;
    logic [PW-1:0] r_phase;
    logic          n_periodic;
    logic [PW-1:0] n_phase;

    always_comb begin
        n_periodic = r_periodic & ~(i_tap_vld && (i_tap != i_byte));
        n_phase    = (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_periodic <= 1'b1;
            r_phase    <= '0;
        end else if (i_ctl.upd) begin
            r_periodic <= n_periodic;
            r_phase    <= n_phase;
        end
    end

    // The count before this byte is at least 2P-1, so the length including it
    // holds at least two whole periods.
    assign o_qual = n_periodic && (n_phase == '0) && (CMPW'(i_count) >= LEN_MIN);

endmodule

// ===== rtl/core/fec_front.sv =====
// Streaming front end: byte history line, length and run counters, summary
// flags and one fec_cell per candidate period. Depends on fec_pkg, fec_cell.
module fec_front #(
    parameter int unsigned MAX_PERIOD  = fec_pkg::MAX_PERIOD_DEF,
    parameter int unsigned COUNT_WIDTH = fec_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    output logic [MAX_PERIOD-1:0]  o_qual,
    output logic [COUNT_WIDTH-1:0] o_len,
    output logic [COUNT_WIDTH-1:0] o_runs,
    output fec_pkg::t_flags        o_flags
);
    import fec_pkg::*;

    logic [7:0]             r_hist [MAX_PERIOD];
    logic [MAX_PERIOD-1:0]  r_hvld;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_runs;
    logic [7:0]             r_prev;
    logic                   r_any;
    logic                   r_sat;

    t_cell_ctl ctl;
    logic      full;
    logic      run_inc;

    assign full    = &r_count;
    assign ctl.upd = i_accept && !r_sat && !full;
    assign ctl.clr = i_accept && i_last;
    assign run_inc = ctl.upd && ((r_count == '0) || (i_byte != r_prev));

    // Tap k holds the byte k+1 places back; its valid bit says it exists.
    always_ff @(posedge i_clk) begin
        if (ctl.upd) begin
            r_hist[0] <= i_byte;
            for (int k = 1; k < MAX_PERIOD; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clr) begin
            r_hvld  <= '0;
            r_count <= '0;
            r_runs  <= '0;
            r_prev  <= '0;
            r_any   <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            if (ctl.upd) begin
                r_hvld  <= {r_hvld, 1'b1} >> 0 == '0 ? r_hvld : MAX_PERIOD'({r_hvld, 1'b1});
                r_count <= r_count + 1'b1;
                r_runs  <= r_runs + COUNT_WIDTH'(run_inc);
            end
            if (i_accept) begin
                r_prev <= i_byte;
                r_any  <= r_any | (i_byte != 8'd0);
                if (!r_sat && full) begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

    for (genvar k = 0; k < MAX_PERIOD; k++) begin : g_cell
        fec_cell #(
            .P           (k + 1),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_byte    (i_byte),
            .i_tap     (r_hist[k]),
            .i_tap_vld (r_hvld[k]),
            .i_count   (r_count),
            .o_qual    (o_qual[k])
        );
    end

    // State of the payload including the current byte, used on its last byte.
    assign o_len          = ctl.upd ? r_count + 1'b1 : r_count;
    assign o_runs         = r_runs + COUNT_WIDTH'(run_inc);
    assign o_flags.any_nz = r_any | (i_byte != 8'd0);
    assign o_flags.sat    = r_sat | full;

endmodule

// ===== rtl/core/fec_pick.sv =====
// Result pipeline: snapshot of a finished payload, grouped search for the
// shortest period, cost comparison and the output register. Depends on fec_pkg.
module fec_pick #(
    parameter int unsigned MAX_PERIOD  = fec_pkg::MAX_PERIOD_DEF,
    parameter int unsigned COUNT_WIDTH = fec_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned PERIOD_W    = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [MAX_PERIOD-1:0]      i_qual,
    input  logic [COUNT_WIDTH-1:0]     i_len,
    input  logic [COUNT_WIDTH-1:0]     i_runs,
    input  fec_pkg::t_flags            i_flags,
    output logic                       o_ready,
    output logic                       o_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_enc,
    output logic [fec_pkg::SIZE_W-1:0] o_size,
    output logic [PERIOD_W-1:0]        o_period,
    output logic [fec_pkg::SIZE_W-1:0] o_runs,
    output logic                       o_too_long
);
    import fec_pkg::*;

    localparam int unsigned NG  = (MAX_PERIOD + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned QW  = NG * GROUP_SIZE;
    localparam int unsigned GIW = $clog2(GROUP_SIZE);
    localparam int unsigned BW  = COUNT_WIDTH + 3;

    // Stage 1: snapshot.
    logic                   r_s1v;
    logic [QW-1:0]          r_s1_qual;
    logic [COUNT_WIDTH-1:0] r_s1_len;
    logic [COUNT_WIDTH-1:0] r_s1_runs;
    t_flags                 r_s1_flags;

    // Stage 2: group search and run-length decision.
    logic                   r_s2v;
    logic [NG-1:0]          r_s2_gf;
    logic [GIW-1:0]         r_s2_gi [NG];
    logic [BW-1:0]          r_s2_best;
    logic [1:0]             r_s2_enc;
    logic [COUNT_WIDTH-1:0] r_s2_runs;
    logic                   r_s2_pat_ok;
    logic                   r_s2_sat;

    // Output register.
    logic                   r_ov;
    logic [1:0]             r_o_enc;
    logic [SIZE_W-1:0]      r_o_size;
    logic [PERIOD_W-1:0]    r_o_period;
    logic [SIZE_W-1:0]      r_o_runs;
    logic                   r_o_too_long;

    logic out_free;
    logic s2_free;
    logic s1_free;

    logic [NG-1:0]  n_s2_gf;
    logic [GIW-1:0] n_s2_gi [NG];
    logic [BW-1:0]  rle_cost;
    logic           rle_ok;
    logic [BW-1:0]  n_s2_best;
    logic [1:0]     n_s2_enc;

    logic                pfound;
    logic [PERIOD_W-1:0] pper;
    logic [BW-1:0]       pat_cost;
    logic                take_pat;

    assign out_free = !r_ov || i_out_ready;
    assign s2_free  = !r_s2v || out_free;
    assign s1_free  = !r_s1v || s2_free;
    assign o_ready  = s1_free;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_s2_gf[g] = 1'b0;
            n_s2_gi[g] = '0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
                if (r_s1_qual[g * GROUP_SIZE + j]) begin
                    n_s2_gf[g] = 1'b1;
                    n_s2_gi[g] = GIW'(j);
                end
            end
        end
    end

    // Five bytes a run, formed as four times the runs plus the runs.
    always_comb begin
        rle_cost = BW'({r_s1_runs, 2'b00}) + BW'(r_s1_runs) + BW'(HDR_BYTES);
        rle_ok   = !r_s1_flags.sat && (rle_cost < BW'(r_s1_len));
        if (!r_s1_flags.any_nz) begin
            n_s2_enc  = ENC_ZERO;
            n_s2_best = '0;
        end else if (rle_ok) begin
            n_s2_enc  = ENC_RLE;
            n_s2_best = rle_cost;
        end else begin
            n_s2_enc  = ENC_RAW;
            n_s2_best = BW'(r_s1_len);
        end
    end

    always_comb begin
        pfound = 1'b0;
        pper   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_s2_gf[g]) begin
                pfound = 1'b1;
                pper   = PERIOD_W'(g * GROUP_SIZE) + PERIOD_W'(r_s2_gi[g]) + PERIOD_W'(1);
            end
        end
        pat_cost = BW'(pper) + BW'(HDR_BYTES);
        take_pat = r_s2_pat_ok && pfound && (pat_cost < r_s2_best);
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_load) begin
            r_s1_qual  <= QW'(i_qual);
            r_s1_len   <= i_len;
            r_s1_runs  <= i_runs;
            r_s1_flags <= i_flags;
        end
        if (s2_free && r_s1v) begin
            r_s2_gf     <= n_s2_gf;
            r_s2_gi     <= n_s2_gi;
            r_s2_best   <= n_s2_best;
            r_s2_enc    <= n_s2_enc;
            r_s2_runs   <= r_s1_runs;
            r_s2_pat_ok <= r_s1_flags.any_nz && !r_s1_flags.sat;
            r_s2_sat    <= r_s1_flags.sat;
        end
        if (out_free && r_s2v) begin
            r_o_enc      <= take_pat ? ENC_PATTERN : r_s2_enc;
            r_o_size     <= SIZE_W'(take_pat ? pat_cost : r_s2_best);
            r_o_period   <= take_pat ? pper : '0;
            r_o_runs     <= (!take_pat && (r_s2_enc == ENC_RLE)) ? SIZE_W'(r_s2_runs) : '0;
            r_o_too_long <= r_s2_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1v <= i_load;
            end
            if (s2_free) begin
                r_s2v <= r_s1v;
            end
            if (out_free) begin
                r_ov <= r_s2v;
            end
        end
    end

    assign o_valid    = r_ov;
    assign o_enc      = r_o_enc;
    assign o_size     = r_o_size;
    assign o_period   = r_o_period;
    assign o_runs     = r_o_runs;
    assign o_too_long = r_o_too_long;

    a_zero_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_o_enc == ENC_ZERO) |-> (r_o_size == '0) && (r_o_period == '0)
            && (r_o_runs == '0))
        else $error("zero result carries a size, period or run count");

    a_pattern_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_o_enc == ENC_PATTERN) |-> (r_o_period != '0) && !r_o_too_long)
        else $error("pattern result without a period or after saturation");

    a_sat_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_too_long |-> (r_o_enc == ENC_RAW) || (r_o_enc == ENC_ZERO))
        else $error("saturated length gave a compressed encoding");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_out_ready |=> r_ov)
        else $error("stalled result was dropped");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1v && r_s2v && r_ov && !i_out_ready |-> !o_ready)
        else $error("input taken with every result stage full");

endmodule

// ===== rtl/core/fill_encoding_chooser_top.sv =====
// Fill encoding chooser: input byte stream in, one encoding decision per payload out.
// Depends on fec_pkg, fec_front (with fec_cell) and fec_pick.
//
// Usage:
//   Slave channel: one payload byte per item in i_s_tdata, i_s_tlast on the final
//   byte. Master channel: one result item per payload, taken when o_m_tvalid
//   and i_m_tready are both high.
//   Throughput is one byte per clock while o_s_tready is high: each period cell
//   updates its flag and phase from its fixed tap of the history line.
//   The result passes through the snapshot stage, the group search stage and the
//   output register after the last byte is taken, and is then valid on o_m_*.
//   Bytes of the next payload are taken while a result is still pending.
//   When the receiver stalls, results queue in the three result stages; only
//   when all three are full does o_s_tready drop.
//   Reset (i_rst_n low, synchronous) empties the pipeline and returns the
//   payload state to the empty payload; it needs no clearing pass.
//   After each last byte the payload state clears by itself.
module fill_encoding_chooser_top #(
    parameter int unsigned MAX_PERIOD  = fec_pkg::MAX_PERIOD_DEF,
    parameter int unsigned COUNT_WIDTH = fec_pkg::COUNT_WIDTH_DEF,
    localparam int unsigned PERIOD_W   = $clog2(MAX_PERIOD + 1),
    localparam int unsigned FIELD_BITS = 2 + fec_pkg::SIZE_W + PERIOD_W + fec_pkg::SIZE_W,
    localparam int unsigned TDATA_W    = ((FIELD_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // data_byte
    input  logic               i_s_tlast,   // is_last
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // encoding, payload_size, period, run_total
    output logic               o_m_tuser    // too_long
);
    import fec_pkg::*;

    logic                   accept;
    logic [MAX_PERIOD-1:0]  qual;
    logic [COUNT_WIDTH-1:0] len;
    logic [COUNT_WIDTH-1:0] runs;
    t_flags                 flags;

    logic [1:0]          enc;
    logic [SIZE_W-1:0]   size;
    logic [PERIOD_W-1:0] period;
    logic [SIZE_W-1:0]   run_total;

    assign accept = i_s_tvalid && o_s_tready;

    fec_front #(
        .MAX_PERIOD  (MAX_PERIOD),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_qual   (qual),
        .o_len    (len),
        .o_runs   (runs),
        .o_flags  (flags)
    );

    fec_pick #(
        .MAX_PERIOD  (MAX_PERIOD),
        .COUNT_WIDTH (COUNT_WIDTH),
        .PERIOD_W    (PERIOD_W)
    ) u_pick (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && i_s_tlast),
        .i_qual      (qual),
        .i_len       (len),
        .i_runs      (runs),
        .i_flags     (flags),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_enc       (enc),
        .o_size      (size),
        .o_period    (period),
        .o_runs      (run_total),
        .o_too_long  (o_m_tuser)
    );

    assign o_m_tdata = TDATA_W'({run_total, period, size, enc});

endmodule

// ===== test/tb_fill_encoding_chooser_top.sv =====
// Testbench for fill_encoding_chooser_top: streams payloads byte by byte and checks each
// encoding decision against a behavioral model of the chooser.
// Depends on fec_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 100ps

module tb_fill_encoding_chooser_top;
    import fec_pkg::*;

    localparam int unsigned PERIOD_W     = $clog2(MAX_PERIOD_DEF + 1);
    localparam int unsigned TDATA_W      = ((2 + 32 + PERIOD_W + 32 + 7) / 8) * 8;
    localparam int unsigned HEADER_COST  = 4;
    localparam int unsigned PER_RUN_COST = 5;
    localparam int unsigned RANDOM_BYTES = 1100;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLDOFF_LEN  = 300;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef bit [7:0] t_octet_q [$];

    typedef struct {
        bit [7:0] data;
        bit       last;
    } t_pay_item;

    typedef struct {
        logic [1:0]          encoding;
        logic [31:0]         payload_size;
        logic [PERIOD_W-1:0] period;
        logic [31:0]         run_total;
        logic                too_long;
    } t_fill_choice;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [7:0]         s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;   // encoding, payload_size, period, run_total
    logic               m_tuser;   // too_long

    t_pay_item    pending_bytes[$];
    t_octet_q     open_payload;
    t_fill_choice expected_choices[$];

    int unsigned total_bytes = 0;
    int unsigned bytes_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_done = 1'b0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    fill_encoding_chooser_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Decision for one complete payload. The length counter cannot saturate
    // within any payload sent here, so the too-long flag is always clear.
    function automatic t_fill_choice choose_encoding(input t_octet_q bytes);
        t_fill_choice c;
        int unsigned  len;
        int unsigned  runs;
        int unsigned  best;
        int unsigned  p;
        int unsigned  i;
        bit           any_nz;
        bit           repeats;
        bit           found;
        len = bytes.size();
        runs = 0;
        any_nz = 1'b0;
        for (i = 0; i < len; i++) begin
            if (bytes[i] != 8'h00)
                any_nz = 1'b1;
            if (i == 0 || bytes[i] != bytes[i-1])
                runs++;
        end
        c.encoding = ENC_RAW;
        c.payload_size = len;
        c.period = '0;
        c.run_total = '0;
        c.too_long = 1'b0;
        if (!any_nz) begin
            c.encoding = ENC_ZERO;
            c.payload_size = '0;
            return c;
        end
        best = len;
        if (HEADER_COST + PER_RUN_COST * runs < len) begin
            c.encoding = ENC_RLE;
            best = HEADER_COST + PER_RUN_COST * runs;
            c.run_total = runs;
        end
        // Smallest period that divides the length and repeats at least twice.
        found = 1'b0;
        for (p = 1; p <= MAX_PERIOD_DEF && 2 * p <= len && !found; p++) begin
            if (len % p == 0) begin
                repeats = 1'b1;
                for (i = p; i < len && repeats; i++)
                    if (bytes[i] != bytes[i-p])
                        repeats = 1'b0;
                if (repeats) begin
                    found = 1'b1;
                    if (HEADER_COST + p < best) begin
                        c.encoding = ENC_PATTERN;
                        best = HEADER_COST + p;
                        c.period = PERIOD_W'(p);
                        c.run_total = '0;
                    end
                end
            end
        end
        c.payload_size = best;
        return c;
    endfunction

    task automatic queue_payload(input t_octet_q bytes);
        t_pay_item it;
        for (int i = 0; i < bytes.size(); i++) begin
            it.data = bytes[i];
            it.last = (i == bytes.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic note_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v,
                     got_v);
    endtask

    // Sender idles little and receiver much, then the reverse, then neither.
    always_comb begin
        if (bytes_taken < total_bytes / 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 81;
        end else if (bytes_taken < 2 * total_bytes / 3) begin
            send_idle_pct = 81;
            recv_idle_pct = 8;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    always @(posedge i_clk) begin : drive_bytes
        t_pay_item nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= nxt.data;
                s_tlast <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // One long hold-off late in the run, while the sender never idles, so that
    // results pile up inside the block and its input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && bytes_taken >= 5 * total_bytes / 6) begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            open_payload.push_back(s_tdata);
            bytes_taken <= bytes_taken + 1;
            if (s_tlast) begin
                expected_choices.push_back(choose_encoding(open_payload));
                open_payload.delete();
            end
        end
    end

    always @(posedge i_clk) begin : check_choices
        t_fill_choice want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_choices.size() == 0) begin
                note_mismatch("result with none pending, encoding", 0, m_tdata[1:0]);
            end else begin
                want = expected_choices.pop_front();
                if (m_tdata[1:0] !== want.encoding)
                    note_mismatch("encoding", want.encoding, m_tdata[1:0]);
                if (m_tdata[33:2] !== want.payload_size)
                    note_mismatch("payload_size", want.payload_size, m_tdata[33:2]);
                if (m_tdata[34 +: PERIOD_W] !== want.period)
                    note_mismatch("period", want.period, m_tdata[34 +: PERIOD_W]);
                if (m_tdata[34 + PERIOD_W +: 32] !== want.run_total)
                    note_mismatch("run_total", want.run_total, m_tdata[34 + PERIOD_W +: 32]);
                if (m_tuser !== want.too_long)
                    note_mismatch("too_long", want.too_long, m_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_octet_q    pl;
        int unsigned random_bytes;
        int unsigned kind;
        int unsigned per;
        int unsigned reps;
        int unsigned nruns;
        int unsigned rlen;
        bit [7:0]    val;
        bit          long_done;

        // Directed payloads: lone zero and lone 0xFF, all zeros, a pattern that
        // wins, a pattern that only ties with raw, and plain raw data.
        queue_payload('{8'h00});
        queue_payload('{8'hFF});
        queue_payload('{8'h00, 8'h00, 8'h00});
        queue_payload('{8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02});
        queue_payload('{8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5});
        queue_payload('{8'h80, 8'h7F, 8'h00, 8'h01});

        random_bytes = 0;
        long_done = 1'b0;
        while (random_bytes < RANDOM_BYTES) begin
            pl.delete();
            kind = $urandom_range(9);
            if (!long_done && random_bytes > RANDOM_BYTES / 4) begin
                // Pattern at the largest period the block searches.
                for (int i = 0; i < MAX_PERIOD_DEF; i++)
                    pl.push_back(8'($urandom_range(255)));
                for (int i = 0; i < MAX_PERIOD_DEF; i++)
                    pl.push_back(pl[i]);
                long_done = 1'b1;
            end else begin
                case (kind)
                    0: begin
                        rlen = $urandom_range(1, 12);
                        for (int i = 0; i < rlen; i++)
                            pl.push_back(8'h00);
                    end
                    1, 2: begin
                        nruns = $urandom_range(1, 4);
                        for (int r = 0; r < nruns; r++) begin
                            val = 8'($urandom_range(255));
                            rlen = $urandom_range(1, 12);
                            for (int i = 0; i < rlen; i++)
                                pl.push_back(val);
                        end
                    end
                    3, 4, 5: begin
                        per = ($urandom_range(7) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
                        reps = (per > 8) ? 2 : $urandom_range(2, 6);
                        for (int i = 0; i < per; i++)
                            pl.push_back(8'($urandom_range(255)));
                        for (int i = per; i < per * reps; i++)
                            pl.push_back(pl[i - per]);
                        // Some patterns are broken by one byte or by a ragged end.
                        case ($urandom_range(3))
                            0: begin
                                rlen = $urandom_range(pl.size() - 1);
                                pl[rlen] = pl[rlen] ^ 8'($urandom_range(1, 255));
                            end
                            1: begin
                                if (pl.size() > 2)
                                    void'(pl.pop_back());
                                else
                                    pl.push_back(8'($urandom_range(255)));
                            end
                            default: ;
                        endcase
                    end
                    6: begin
                        rlen = $urandom_range(1, 20);
                        for (int i = 0; i < rlen; i++)
                            pl.push_back(8'($urandom_range(255)));
                    end
                    7: pl.push_back(8'($urandom_range(255)));
                    default: begin
                        rlen = $urandom_range(1, 16);
                        for (int i = 0; i < rlen; i++)
                            pl.push_back(($urandom_range(3) == 0) ? 8'hFF : 8'h00);
                    end
                endcase
            end
            random_bytes += pl.size();
            queue_payload(pl);
        end
        total_bytes = pending_bytes.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (expected_choices.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_choices.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fec_pkg.sv
rtl/core/fec_cell.sv
rtl/core/fec_front.sv
rtl/core/fec_pick.sv
rtl/core/fill_encoding_chooser_top.sv
test/tb_fill_encoding_chooser_top.sv
